[hw/rtl/ftcd_pkg.sv]
// ----------------------------------------------------------------------------
// ftcd_pkg
// Shared types and constants of the tile cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package ftcd_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int LEVEL_W = 8;
    localparam int COORD_W = 20;
    localparam int KEY_W   = LEVEL_W + 2 * COORD_W;
    localparam int REF_W   = 32;
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REF_W-1:0] tref;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/fifo_tile_cache_directory.sv]
// ----------------------------------------------------------------------------
// fifo_tile_cache_directory
// Fully associative tile directory with first-in first-out replacement.
// ----------------------------------------------------------------------------
// One item is worked at a time. Lookup and insert scan the filled slots
// through the single read port of the entry memory, one slot per cycle; a
// hit ends the scan early. Clear and the unused code skip the scan and go
// straight to the output stage. Slots fill in order, so the fill count marks
// the valid entries and no clearing pass is needed. A finished result sits
// in an output register while the next item is accepted.
`default_nettype none

module fifo_tile_cache_directory (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [ftcd_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [ftcd_pkg::LEVEL_W-1:0] i_level,
    input  wire logic [ftcd_pkg::COORD_W-1:0] i_tile_col,
    input  wire logic [ftcd_pkg::COORD_W-1:0] i_tile_row,
    input  wire logic [ftcd_pkg::REF_W-1:0]   i_tile_ref,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_hit,
    output logic [ftcd_pkg::REF_W-1:0]        o_ref_out,
    output logic                              o_evicted
);
    import ftcd_pkg::*;

    t_entry mem [ENTRIES];

    t_state             r_state, n_state;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [REF_W-1:0]   r_ref_in, n_ref_in;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_rd_vld, n_rd_vld;
    t_entry             r_rd_data;
    logic               r_res_hit, n_res_hit;
    logic [REF_W-1:0]   r_res_ref, n_res_ref;
    logic               r_res_evict, n_res_evict;
    logic               r_o_valid, n_o_valid;
    logic               r_o_hit, n_o_hit;
    logic [REF_W-1:0]   r_o_ref, n_o_ref;
    logic               r_o_evict, n_o_evict;

    logic               in_acc;
    logic               match;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic               full;
    logic               out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign match    = r_rd_vld && (r_rd_data.key == r_key);
    assign full     = (r_count == CNT_W'(ENTRIES));
    assign out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_ref_in    = r_ref_in;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_res_hit   = r_res_hit;
        n_res_ref   = r_res_ref;
        n_res_evict = r_res_evict;
        n_o_valid   = r_o_valid;
        n_o_hit     = r_o_hit;
        n_o_ref     = r_o_ref;
        n_o_evict   = r_o_evict;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = r_count[IDX_W-1:0];

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func      = i_func;
                    n_key       = {i_level, i_tile_row, i_tile_col};
                    n_ref_in    = i_tile_ref;
                    n_addr      = '0;
                    n_res_hit   = 1'b0;
                    n_res_ref   = '0;
                    n_res_evict = 1'b0;
                    if (i_func == FUNC_LOOKUP || i_func == FUNC_INSERT) begin
                        n_state = S_SCAN;
                    end else begin
                        if (i_func == FUNC_CLEAR) begin
                            n_count  = '0;
                            n_oldest = '0;
                        end
                        n_state = S_PUSH;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_res_hit = 1'b1;
                    n_res_ref = r_rd_data.tref;
                    n_state   = S_PUSH;
                end else if (r_addr < r_count) begin
                    rd_en    = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    if (r_func == FUNC_INSERT) begin
                        wr_en = 1'b1;
                        if (full) begin
                            wr_idx      = r_oldest;
                            n_oldest    = (r_oldest == IDX_W'(ENTRIES - 1)) ?
                                          '0 : r_oldest + 1'b1;
                            n_res_evict = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_res_hit;
                    n_o_ref   = r_res_ref;
                    n_o_evict = r_res_evict;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
        end
        if (wr_en) begin
            mem[wr_idx] <= '{key: r_key, tref: r_ref_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_oldest  <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_oldest  <= n_oldest;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_ref_in    <= n_ref_in;
        r_addr      <= n_addr;
        r_res_hit   <= n_res_hit;
        r_res_ref   <= n_res_ref;
        r_res_evict <= n_res_evict;
        r_o_hit     <= n_o_hit;
        r_o_ref     <= n_o_ref;
        r_o_evict   <= n_o_evict;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_hit       = r_o_hit;
    assign o_ref_out   = r_o_ref;
    assign o_evicted   = r_o_evict;

    // fill count never passes the capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("fill count above capacity");

    // replacement pointer moves only once the store is full
    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> full)
        else $error("replacement pointer moved before store filled");

    // an eviction never reports a hit
    a_evict_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_evict |-> !r_o_hit)
        else $error("eviction reported together with hit");

    // clear empties the store
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_func == FUNC_CLEAR) |=> (r_count == '0) && (r_oldest == '0))
        else $error("clear left entries behind");

    // reads are only issued within the filled slots
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_addr < r_count))
        else $error("read beyond filled slots");

endmodule

`default_nettype wire

[tb/tb_fifo_tile_cache_directory.sv]
// ----------------------------------------------------------------------------
// tb_fifo_tile_cache_directory
// Self-checking bench for the FIFO-replacement tile directory. A directed
// table covers key extremes, every function code, duplicate insert and clear.
// Random phases follow: small and large key pools, near-miss keys and
// replacement once all slots are filled. Random replies are compared against
// an in-bench directory model, directed rows against their own table entry.
// Both handshakes idle in random bursts, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_fifo_tile_cache_directory;
    timeunit 1ns;
    timeprecision 1ps;

    import ftcd_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int DIR_N = 21;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [REF_W-1:0]   tref;
    } tile_req_t;

    typedef struct packed {
        logic             hit;
        logic [REF_W-1:0] tref;
        logic             evicted;
    } dir_reply_t;

    typedef struct packed {
        tile_req_t  req;
        logic       fixed;
        dir_reply_t want;
    } dir_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [LEVEL_W-1:0] i_level = '0;
    logic [COORD_W-1:0] i_tile_col = '0;
    logic [COORD_W-1:0] i_tile_row = '0;
    logic [REF_W-1:0]   i_tile_ref = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit;
    logic [REF_W-1:0]   o_ref_out;
    logic               o_evicted;

    fifo_tile_cache_directory dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_level    (i_level),
        .i_tile_col (i_tile_col),
        .i_tile_row (i_tile_row),
        .i_tile_ref (i_tile_ref),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_hit      (o_hit),
        .o_ref_out  (o_ref_out),
        .o_evicted  (o_evicted)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // directory model: slots fill in order, so fill count marks valid slots
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [REF_W-1:0] ref_mem [ENTRIES];
    int unsigned      fill_cnt = 0;
    int unsigned      next_victim = 0;

    dir_reply_t pending_replies [$];
    int         replies_seen = 0;
    int         bad_cnt = 0;
    bit         no_idle = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        '{'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'hff, 20'hfffff, 20'hfffff, 32'hffffffff}, 1'b1,
          '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_INSERT, 8'h00, 20'h00000, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_INSERT, 8'hff, 20'hfffff, 20'hfffff, 32'hffffffff}, 1'b1,
          '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'hff, 20'hfffff, 20'hfffff, 32'h0}, 1'b1,
          '{1'b1, 32'hffffffff, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'h00000, 32'hffffffff}, 1'b1,
          '{1'b1, 32'h0, 1'b0}},
        '{'{FUNC_INSERT, 8'hff, 20'hfffff, 20'hfffff, 32'h12345678}, 1'b1,
          '{1'b1, 32'hffffffff, 1'b0}},
        '{'{FUNC_INSERT, 8'haa, 20'h55555, 20'haaaaa, 32'ha5a5a5a5}, 1'b1,
          '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h55, 20'haaaaa, 20'h55555, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'haa, 20'h55555, 20'haaaaa, 32'h0}, 1'b1,
          '{1'b1, 32'ha5a5a5a5, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h00, 20'hfffff, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'hfffff, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'hff, 20'h00000, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_SPARE, 8'hff, 20'hfffff, 20'hfffff, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'hff, 20'hfffff, 20'hfffff, 32'h0}, 1'b1,
          '{1'b1, 32'hffffffff, 1'b0}},
        '{'{FUNC_CLEAR, 8'hff, 20'hfffff, 20'hfffff, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'hff, 20'hfffff, 20'hfffff, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_INSERT, 8'h00, 20'h00000, 20'hfffff, 32'h5a5a5a5a}, 1'b1,
          '{1'b0, 32'h0, 1'b0}},
        '{'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'hfffff, 32'h0}, 1'b1,
          '{1'b1, 32'h5a5a5a5a, 1'b0}},
        '{'{FUNC_CLEAR, 8'h00, 20'h00000, 20'h00000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}}
    };

    function automatic dir_reply_t predict_reply(tile_req_t r);
        logic [KEY_W-1:0] k;
        dir_reply_t       a;
        int               slot;
        k = {r.level, r.row, r.col};
        a = '0;
        slot = -1;
        if (r.func == FUNC_LOOKUP || r.func == FUNC_INSERT) begin
            for (int i = 0; i < int'(fill_cnt); i++) begin
                if (slot < 0 && key_mem[i] == k) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                a.hit = 1'b1;
                a.tref = ref_mem[slot];
            end else if (r.func == FUNC_INSERT) begin
                if (fill_cnt < ENTRIES) begin
                    slot = fill_cnt;
                    fill_cnt++;
                end else begin
                    slot = next_victim;
                    next_victim = (next_victim + 1) % ENTRIES;
                    a.evicted = 1'b1;
                end
                key_mem[slot] = k;
                ref_mem[slot] = r.tref;
            end
        end else if (r.func == FUNC_CLEAR) begin
            fill_cnt = 0;
            next_victim = 0;
        end
        return a;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [LEVEL_W-1:0] lv;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] rw;
        lv = LEVEL_W'($urandom());
        c = COORD_W'($urandom());
        rw = COORD_W'($urandom());
        case ($urandom_range(0, 15))
            0: lv = '0;
            1: lv = '1;
            2: c = '0;
            3: c = '1;
            4: rw = '0;
            5: rw = '1;
            default: ;
        endcase
        return {lv, rw, c};
    endfunction

    task automatic offer(tile_req_t r, logic fixed, dir_reply_t want);
        dir_reply_t p;
        i_in_valid <= 1'b1;
        i_func <= r.func;
        i_level <= r.level;
        i_tile_col <= r.col;
        i_tile_row <= r.row;
        i_tile_ref <= r.tref;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        p = predict_reply(r);
        pending_replies.push_back(fixed ? want : p);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_items, int pool_n, bit with_clear);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] k;
        tile_req_t        r;
        int               sel;
        int               idx;
        repeat (pool_n) pool.push_back(fresh_key());
        repeat (n_items) begin
            sel = $urandom_range(0, 99);
            k = pool[$urandom_range(0, pool.size() - 1)];
            r.tref = $urandom();
            r.func = FUNC_LOOKUP;
            if (sel < 45) begin
                r.func = FUNC_INSERT;
            end else if (sel >= 88 && sel < 94) begin
                idx = $urandom_range(0, KEY_W - 1);
                k[idx] = ~k[idx];
            end else if (sel >= 94 && sel < 98) begin
                k = fresh_key();
            end else if (sel == 98) begin
                r.func = with_clear ? FUNC_CLEAR : FUNC_LOOKUP;
            end else if (sel == 99) begin
                r.func = FUNC_SPARE;
            end
            {r.level, r.row, r.col} = k;
            offer(r, 1'b0, '0);
        end
    endtask

    task automatic report_bad(string what, logic [REF_W-1:0] want, logic [REF_W-1:0] got);
        bad_cnt++;
        if (bad_cnt <= 10) begin
            $display("reply %0d %s: expected %h, got %h", replies_seen, what, want, got);
        end
    endtask

    initial begin
        int         hold_left;
        int         stall_left;
        bit         long_done;
        dir_reply_t want;
        hold_left = 0;
        stall_left = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    report_bad("arrived with none pending", '0, o_ref_out);
                end else begin
                    want = pending_replies.pop_front();
                    if (o_hit !== want.hit) begin
                        report_bad("hit", REF_W'(want.hit), REF_W'(o_hit));
                    end
                    if (o_ref_out !== want.tref) report_bad("ref_out", want.tref, o_ref_out);
                    if (o_evicted !== want.evicted) begin
                        report_bad("evicted", REF_W'(want.evicted), REF_W'(o_evicted));
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!long_done && replies_seen >= 500) begin
                long_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < DIR_N; n++) begin
            offer(dir_rows[n].req, dir_rows[n].fixed, dir_rows[n].want);
        end
        wait_drained();
        run_phase(300, 64, 1'b1);
        wait_drained();
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
        run_phase(480, 200, 1'b0);
        wait_drained();
        no_idle = 1'b1;
        run_phase(250, 150, 1'b1);
        wait_drained();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (bad_cnt == 0 && pending_replies.size() == 0) begin
            $display("fifo_tile_cache_directory: match");
        end else begin
            $display("fifo_tile_cache_directory: mismatch");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("fifo_tile_cache_directory: mismatch");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ftcd_pkg.sv
hw/rtl/fifo_tile_cache_directory.sv
tb/tb_fifo_tile_cache_directory.sv
